>>> hw/rtl/ipc_pkg.sv
// Shared types and constants for the irrigation pump controller.
// No dependencies; every other file of the block depends on this package.
package ipc_pkg;

   // Field widths
   localparam int MOISTURE_BITS = 10;
   localparam int TIME_BITS     = 16;
   localparam int EV_BITS       = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = (TIME_BITS > MOISTURE_BITS) ? TIME_BITS : MOISTURE_BITS;

   // Register reset values
   localparam logic [MOISTURE_BITS-1:0] MOISTURE_LOW_RST  = MOISTURE_BITS'(300);
   localparam logic [MOISTURE_BITS-1:0] MOISTURE_HIGH_RST = MOISTURE_BITS'(700);
   localparam logic [TIME_BITS-1:0]     MAX_WATER_RST     = TIME_BITS'(60);
   localparam logic [TIME_BITS-1:0]     MANUAL_RUN_RST    = TIME_BITS'(10);

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MOISTURE_LOW  = 2'd0,
      CSR_MOISTURE_HIGH = 2'd1,
      CSR_MAX_WATERING  = 2'd2,
      CSR_MANUAL_RUN    = 2'd3
   } csr_idx_type;

   // Event kinds
   typedef enum logic [EV_BITS-1:0] {
      EV_TICK     = 2'd0,
      EV_SAMPLE   = 2'd1,
      EV_MODE_BTN = 2'd2,
      EV_PUMP_BTN = 2'd3
   } ev_kind_type;

   typedef struct packed {
      logic [MOISTURE_BITS-1:0] moisture_low;
      logic [MOISTURE_BITS-1:0] moisture_high;
      logic [TIME_BITS-1:0]     max_watering_seconds;
      logic [TIME_BITS-1:0]     manual_run_seconds;
   } cfg_type;

   typedef struct packed {
      ev_kind_type              kind;
      logic [MOISTURE_BITS-1:0] moisture;
   } item_type;

   typedef struct packed {
      logic                 manual_mode;
      logic                 pump_running;
      logic                 lamp_watering;
      logic [TIME_BITS-1:0] run_elapsed;
      logic                 manual_busy;
      logic [TIME_BITS-1:0] manual_remaining;
   } ctl_state_type;

   typedef struct packed {
      logic pump_on;
      logic watering_lamp;
      logic manual_mode;
   } result_type;

endpackage

>>> hw/rtl/ipc_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// Depends on ipc_pkg for the field widths.
interface ipc_req_if;
   logic                             valid;
   logic                             ready;
   logic [ipc_pkg::EV_BITS-1:0]      mode;
   logic [ipc_pkg::MOISTURE_BITS-1:0] moisture;

   modport source (output valid, output mode, output moisture, input ready);
   modport sink   (input valid, input mode, input moisture, output ready);
endinterface

interface ipc_rsp_if;
   logic valid;
   logic ready;
   logic pump_on;
   logic watering_lamp;
   logic manual_mode;

   modport source (output valid, output pump_on, output watering_lamp, output manual_mode,
                   input ready);
   modport sink   (input valid, input pump_on, input watering_lamp, input manual_mode,
                   output ready);
endinterface

>>> hw/rtl/irrigation_pump_controller.sv
// Top level of the irrigation pump controller.
// Depends on ipc_pkg, ipc_if, ipc_csr, ipc_in_stage and ipc_ctrl.

// Each event transfer (tick, moisture sample, mode button, pump button) yields exactly one
// result with the pump, lamp and mode after that event. Events are taken one per cycle
// back to back while the result side keeps draining; a result passes through the input register
// and then the result register, with the single compare-and-count pass between them. A
// stalled result side holds one result and one event before ready drops. Write the
// configuration registers only while no event is in flight.
module irrigation_pump_controller (
   input  logic                              clock,
   input  logic                              reset,
   ipc_req_if.sink                           req,
   ipc_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [ipc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ipc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import ipc_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     take;

   ipc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ipc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp        (rsp)
   );

endmodule

>>> hw/rtl/ipc_csr.sv
// Configuration registers: thresholds and run lengths, written by index.
// Depends on ipc_pkg.
module ipc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ipc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [ipc_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output ipc_pkg::cfg_type                  cfg
);
   import ipc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MOISTURE_LOW:  cfg_in.moisture_low         = csr_wdata[MOISTURE_BITS-1:0];
            CSR_MOISTURE_HIGH: cfg_in.moisture_high        = csr_wdata[MOISTURE_BITS-1:0];
            CSR_MAX_WATERING:  cfg_in.max_watering_seconds = csr_wdata[TIME_BITS-1:0];
            CSR_MANUAL_RUN:    cfg_in.manual_run_seconds   = csr_wdata[TIME_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.moisture_low         <= MOISTURE_LOW_RST;
         cfg_ff.moisture_high        <= MOISTURE_HIGH_RST;
         cfg_ff.max_watering_seconds <= MAX_WATER_RST;
         cfg_ff.manual_run_seconds   <= MANUAL_RUN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/ipc_in_stage.sv
// Input register for event transfers; frees itself when the controller takes the event.
// Depends on ipc_pkg and the ipc_req_if interface.
module ipc_in_stage (
   input  logic              clock,
   input  logic              reset,
   ipc_req_if.sink           req,
   input  logic              take,
   output logic              item_valid,
   output ipc_pkg::item_type item
);
   import ipc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   // Accept when empty or when the held event moves on this cycle
   assign req.ready = !valid_ff || take;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload; no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind     <= ev_kind_type'(req.mode);
         item_ff.moisture <= req.moisture;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/ipc_ctrl.sv
// Controller state update and result register: one event per cycle unless a held result is stalled.
// Depends on ipc_pkg and the ipc_rsp_if interface.
module ipc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  ipc_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  ipc_pkg::item_type item,
   output logic              take,
   ipc_rsp_if.source         rsp
);
   import ipc_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;
   ctl_state_type nxt;
   logic          out_valid_ff;
   logic          out_valid_in;
   result_type    out_ff;

   // Move the event on when the result register is empty or being drained
   assign take = item_valid && (!out_valid_ff || rsp.ready);

   // Next state for the held event
   always_comb begin
      nxt = state_ff;
      if (state_ff.manual_busy) begin
         if (item.kind == EV_TICK) begin
            if (state_ff.manual_remaining > TIME_BITS'(1)) begin
               nxt.manual_remaining = state_ff.manual_remaining - TIME_BITS'(1);
            end else begin
               nxt.manual_remaining = '0;
               nxt.manual_busy      = 1'b0;
               nxt.pump_running     = 1'b0;
               nxt.lamp_watering    = 1'b0;
            end
         end
      end else begin
         unique case (item.kind)
            EV_TICK: begin
               if (!state_ff.manual_mode && state_ff.pump_running &&
                   state_ff.run_elapsed != '1) begin
                  nxt.run_elapsed = state_ff.run_elapsed + TIME_BITS'(1);
               end
            end
            EV_SAMPLE: begin
               if (!state_ff.manual_mode) begin
                  if (!state_ff.pump_running) begin
                     if (item.moisture <= cfg.moisture_low) begin
                        nxt.pump_running  = 1'b1;
                        nxt.lamp_watering = 1'b1;
                        nxt.run_elapsed   = '0;
                     end
                  end else if (item.moisture >= cfg.moisture_high ||
                               state_ff.run_elapsed >= cfg.max_watering_seconds) begin
                     nxt.pump_running  = 1'b0;
                     nxt.lamp_watering = 1'b0;
                  end
               end
            end
            EV_MODE_BTN: begin
               nxt.manual_mode  = !state_ff.manual_mode;
               nxt.pump_running = 1'b0;
               nxt.run_elapsed  = '0;
            end
            EV_PUMP_BTN: begin
               if (state_ff.manual_mode) begin
                  nxt.pump_running     = 1'b1;
                  nxt.lamp_watering    = 1'b1;
                  nxt.manual_busy      = 1'b1;
                  nxt.manual_remaining = cfg.manual_run_seconds;
               end
            end
            default: nxt = state_ff;
         endcase
      end
   end

   // Commit state only on an event transfer into the result register
   assign state_in = take ? nxt : state_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result with the state after the event
   always_ff @(posedge clock) begin
      if (take) begin
         out_ff.pump_on       <= nxt.pump_running;
         out_ff.watering_lamp <= nxt.lamp_watering;
         out_ff.manual_mode   <= nxt.manual_mode;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.pump_on       = out_ff.pump_on;
   assign rsp.watering_lamp = out_ff.watering_lamp;
   assign rsp.manual_mode   = out_ff.manual_mode;

   // A manual run only exists in manual mode with the pump on
   a_busy_implies_run: assert property (@(posedge clock) disable iff (reset)
      state_ff.manual_busy |-> (state_ff.manual_mode && state_ff.pump_running))
      else $error("manual run without manual mode or pump");

   // The run timer only counts in auto mode
   a_elapsed_auto_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff.run_elapsed != '0) |-> !state_ff.manual_mode)
      else $error("run timer set in manual mode");

   // A pending result always reflects the current controller state
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.pump_on == state_ff.pump_running &&
                        out_ff.watering_lamp == state_ff.lamp_watering &&
                        out_ff.manual_mode == state_ff.manual_mode))
      else $error("result register out of step with state");

   // A result appears only after an event transfer
   a_result_from_take: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(take))
      else $error("result without event");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the irrigation pump controller: auto and manual watering,
// run limits and register settings. Depends on ipc_pkg, ipc_if and the controller RTL.
module testbench;
   import ipc_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      ev_kind_type              kind;
      logic [MOISTURE_BITS-1:0] level;
      int unsigned              gap;
      bit                       drain;
   } pump_event_type;

   logic clock = 1'b0;
   logic reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   ipc_req_if req_ch ();
   ipc_rsp_if rsp_ch ();

   irrigation_pump_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Controller state as predicted from the accepted events
   cfg_type              cfg;
   logic                 manual_sel;
   logic                 pump_run;
   logic                 lamp_lit;
   logic [TIME_BITS-1:0] water_secs;
   logic                 manual_active;
   logic [TIME_BITS-1:0] manual_left;

   pump_event_type event_q[$];
   result_type     pump_status_q[$];

   int unsigned events_queued   = 0;
   int unsigned events_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned error_count     = 0;
   int unsigned settings_count  = 0;
   int unsigned kind_count[4]   = '{0, 0, 0, 0};
   int unsigned quiet_cycles    = 0;
   int unsigned req_gap_max     = 10;
   int unsigned rsp_stall_max   = 10;
   int unsigned gap_left        = 0;
   int unsigned stall_left      = 0;
   logic        req_taken       = 1'b0;
   logic        rsp_taken       = 1'b0;

   // Advance the controller state by one event and return the status it shows after it
   function automatic result_type next_pump_status(ev_kind_type kind,
                                                   logic [MOISTURE_BITS-1:0] level);
      result_type status;
      if (manual_active) begin
         // a manual run only listens to ticks
         if (kind == EV_TICK) begin
            if (manual_left > 1) begin
               manual_left = manual_left - 1'b1;
            end else begin
               manual_left   = '0;
               manual_active = 1'b0;
               pump_run      = 1'b0;
               lamp_lit      = 1'b0;
            end
         end
      end else begin
         case (kind)
            EV_TICK: begin
               if (!manual_sel && pump_run && water_secs != '1)
                  water_secs = water_secs + 1'b1;
            end
            EV_SAMPLE: begin
               if (!manual_sel) begin
                  if (!pump_run) begin
                     if (level <= cfg.moisture_low) begin
                        pump_run   = 1'b1;
                        lamp_lit   = 1'b1;
                        water_secs = '0;
                     end
                  end else if (level >= cfg.moisture_high ||
                               water_secs >= cfg.max_watering_seconds) begin
                     pump_run = 1'b0;
                     lamp_lit = 1'b0;
                  end
               end
            end
            EV_MODE_BTN: begin
               // lamp keeps its value on a mode change
               manual_sel = !manual_sel;
               pump_run   = 1'b0;
               water_secs = '0;
            end
            default: begin
               if (manual_sel) begin
                  pump_run      = 1'b1;
                  lamp_lit      = 1'b1;
                  manual_active = 1'b1;
                  manual_left   = cfg.manual_run_seconds;
               end
            end
         endcase
      end
      status.pump_on       = pump_run;
      status.watering_lamp = lamp_lit;
      status.manual_mode   = manual_sel;
      return status;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_checked, what, got, want);
      error_count++;
   endtask

   // Check result transfers against the oldest prediction, then predict new event transfers
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pump_status_q.size() == 0) begin
               report_mismatch("result with no event pending, pump_on", rsp_ch.pump_on, 0);
            end else begin
               want = pump_status_q.pop_front();
               if (rsp_ch.pump_on !== want.pump_on)
                  report_mismatch("pump_on", rsp_ch.pump_on, want.pump_on);
               if (rsp_ch.watering_lamp !== want.watering_lamp)
                  report_mismatch("watering_lamp", rsp_ch.watering_lamp, want.watering_lamp);
               if (rsp_ch.manual_mode !== want.manual_mode)
                  report_mismatch("manual_mode", rsp_ch.manual_mode, want.manual_mode);
            end
            results_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            pump_status_q.push_back(next_pump_status(ev_kind_type'(req_ch.mode),
                                                     req_ch.moisture));
            kind_count[req_ch.mode]++;
            events_accepted++;
         end
      end
   end

   // Event driver: hold until transfer, then idle for the drawn gap before the next event
   always @(negedge clock) begin
      pump_event_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left != 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
         end else if (event_q.size() != 0 &&
                      !(event_q[0].drain && pump_status_q.size() != 0)) begin
            nxt = event_q.pop_front();
            req_ch.valid    <= 1'b1;
            req_ch.mode     <= nxt.kind;
            req_ch.moisture <= nxt.level;
            gap_left        <= nxt.gap;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result side: stall for a drawn number of cycles after each transfer
   always @(negedge clock) begin
      int unsigned n;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (rsp_taken) begin
         n = $urandom_range(0, rsp_stall_max);
         rsp_ch.ready <= (n == 0);
         stall_left   <= (n == 0) ? 0 : n - 1;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Drop the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results still pending",
                     QUIET_LIMIT, pump_status_q.size());
            $display("[irrigation_pump_controller] ERROR");
            $finish;
         end
      end
   end

   task automatic add_event(ev_kind_type kind, logic [MOISTURE_BITS-1:0] level,
                            bit drain = 1'b0);
      pump_event_type e;
      e.kind  = kind;
      e.level = level;
      e.gap   = $urandom_range(0, req_gap_max);
      e.drain = drain;
      event_q.push_back(e);
      events_queued++;
   endtask

   // Favor readings at the thresholds and at the ends of the range
   function automatic logic [MOISTURE_BITS-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return cfg.moisture_low + MOISTURE_BITS'($urandom_range(0, 2)) - 1'b1;
         3: return cfg.moisture_high + MOISTURE_BITS'($urandom_range(0, 2)) - 1'b1;
         default: return MOISTURE_BITS'($urandom);
      endcase
   endfunction

   task automatic add_random_events(int n);
      int unsigned w;
      for (int i = 0; i < n; i++) begin
         w = $urandom_range(0, 99);
         if (w < 45)
            add_event(EV_TICK, pick_level(), $urandom_range(0, 49) == 0);
         else if (w < 80)
            add_event(EV_SAMPLE, pick_level(), $urandom_range(0, 49) == 0);
         else if (w < 88)
            add_event(EV_MODE_BTN, pick_level(), $urandom_range(0, 49) == 0);
         else
            add_event(EV_PUMP_BTN, pick_level(), $urandom_range(0, 49) == 0);
      end
   endtask

   // Wait until every queued event is taken and every predicted result has arrived
   task automatic wait_idle();
      do
         @(negedge clock);
      while (events_accepted != events_queued || pump_status_q.size() != 0);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MOISTURE_LOW:  cfg.moisture_low         = value[MOISTURE_BITS-1:0];
         CSR_MOISTURE_HIGH: cfg.moisture_high        = value[MOISTURE_BITS-1:0];
         CSR_MAX_WATERING:  cfg.max_watering_seconds = value[TIME_BITS-1:0];
         default:           cfg.manual_run_seconds   = value[TIME_BITS-1:0];
      endcase
   endtask

   // Load a full register set once the controller is idle, then set the idling for the phase
   task automatic apply_settings(int unsigned low, int unsigned high, int unsigned max_secs,
                                 int unsigned manual_secs, int unsigned req_max,
                                 int unsigned rsp_max);
      wait_idle();
      write_reg(CSR_MOISTURE_LOW, CSR_DATA_BITS'(low));
      write_reg(CSR_MOISTURE_HIGH, CSR_DATA_BITS'(high));
      write_reg(CSR_MAX_WATERING, CSR_DATA_BITS'(max_secs));
      write_reg(CSR_MANUAL_RUN, CSR_DATA_BITS'(manual_secs));
      req_gap_max   = req_max;
      rsp_stall_max = rsp_max;
      settings_count++;
      @(posedge clock);
   endtask

   initial begin
      int unsigned idle_max;
      req_ch.valid    = 1'b0;
      req_ch.mode     = EV_TICK;
      req_ch.moisture = '0;
      rsp_ch.ready    = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_MOISTURE_LOW;
      csr_wdata       = '0;
      reset           = 1'b1;
      cfg.moisture_low         = MOISTURE_LOW_RST;
      cfg.moisture_high        = MOISTURE_HIGH_RST;
      cfg.max_watering_seconds = MAX_WATER_RST;
      cfg.manual_run_seconds   = MANUAL_RUN_RST;
      manual_sel    = 1'b0;
      pump_run      = 1'b0;
      lamp_lit      = 1'b0;
      water_secs    = '0;
      manual_active = 1'b0;
      manual_left   = '0;
      settings_count = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: start just at low, stop just at high, buttons in auto and manual
      add_event(EV_TICK, '0);
      add_event(EV_SAMPLE, 10'd301);
      add_event(EV_SAMPLE, 10'd300);
      add_event(EV_TICK, '1);
      add_event(EV_TICK, '0);
      add_event(EV_SAMPLE, 10'd699);
      add_event(EV_SAMPLE, 10'd700);
      add_event(EV_SAMPLE, '0);
      add_event(EV_PUMP_BTN, '0);
      add_event(EV_MODE_BTN, '1);
      add_event(EV_SAMPLE, '0);
      add_event(EV_MODE_BTN, '0);

      // Zero-length manual runs, events ignored during a run, run limit on a sample
      apply_settings(300, 700, 1, 0, 10, 10);
      add_event(EV_MODE_BTN, '0, 1'b1);
      add_event(EV_PUMP_BTN, '0);
      add_event(EV_SAMPLE, '1);
      add_event(EV_MODE_BTN, '0);
      add_event(EV_TICK, '0);
      add_event(EV_PUMP_BTN, '1);
      add_event(EV_TICK, '1);
      add_event(EV_MODE_BTN, '0);
      add_event(EV_SAMPLE, '1);
      add_event(EV_SAMPLE, '0);
      add_event(EV_TICK, '0);
      add_event(EV_SAMPLE, 10'd500);

      // Random phases over fixed and drawn settings; the back-to-back phase pauses
      // midway until every result is back
      apply_settings(300, 700, 8, 3, 10, 10);
      add_random_events(80);
      apply_settings(0, 1023, 1, 0, 0, 0);
      add_random_events(40);
      add_event(EV_SAMPLE, '0, 1'b1);
      add_random_events(39);
      apply_settings(1023, 0, 2, 1, 10, 10);
      add_random_events(80);
      for (int p = 0; p < 3; p++) begin
         idle_max = ($urandom_range(0, 1) == 0) ? 0 : 10;
         apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(1, 20), $urandom_range(0, 6), idle_max, 10 - idle_max);
         add_random_events(80);
      end

      // Longest settings: an auto run outlasts a burst of ticks, a long manual run holds
      apply_settings(0, 1023, 65535, 65535, 0, 0);
      if (manual_active) begin
         for (int i = 0; i < ((manual_left > 1) ? manual_left : 1); i++)
            add_event(EV_TICK, '0);
      end
      if (manual_sel)
         add_event(EV_MODE_BTN, '0);
      add_event(EV_SAMPLE, '1);
      add_event(EV_SAMPLE, '0);
      for (int i = 0; i < 16; i++)
         add_event(EV_TICK, MOISTURE_BITS'($urandom));
      add_event(EV_SAMPLE, 10'd1022);
      add_event(EV_MODE_BTN, '0);
      add_event(EV_PUMP_BTN, '0);
      add_event(EV_TICK, '0);
      add_event(EV_TICK, '0);
      add_event(EV_SAMPLE, '0);
      add_event(EV_MODE_BTN, '0);

      wait_idle();
      repeat (4) @(posedge clock);
      $display("covered %0d events: %0d ticks, %0d samples, %0d mode and %0d pump presses",
               events_accepted, kind_count[EV_TICK], kind_count[EV_SAMPLE],
               kind_count[EV_MODE_BTN], kind_count[EV_PUMP_BTN]);
      $display("%0d register settings, %0d results checked, %0d mismatches",
               settings_count, results_checked, error_count);
      if (error_count == 0) begin
         $display("[irrigation_pump_controller] OK");
      end else begin
         $display("[irrigation_pump_controller] ERROR");
      end
      $finish;
   end

endmodule
